FILE: hw/rtl/mpd_pkg.sv
`timescale 1ns / 1ps

package mpd_pkg;

   localparam int FLD_W        = 3;
   localparam int SZ_W         = 8;
   localparam int CSR_DATA_W   = 4;
   localparam int CSR_IDX_W    = 3;
   localparam int MAX_RESULTS  = 64;
   localparam int OUT_CNT_W    = 7;
   localparam int DIR_W        = 3;
   localparam int DEF_MAX_ROWS = 8;
   localparam int DEF_MAX_COLS = 8;

   typedef enum logic [1:0] {
      OP_BLOCK  = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_SEARCH = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      DIR_RIGHT = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_UP    = 2'd3
   } dir_type;

   localparam logic [DIR_W-1:0] DIR_END = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ROW = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_ROW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_COL  = 3'd5;

endpackage

FILE: hw/rtl/mpd_ram.sv
`timescale 1ns / 1ps

module mpd_ram #(
   parameter int WIDTH  = 1,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] ram_ff [2**ADDR_W];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/mpd_nbr.sv
`timescale 1ns / 1ps

module mpd_nbr
   import mpd_pkg::*;
#(
   parameter int ROW_W = 3,
   parameter int COL_W = 3
) (
   input  logic [ROW_W-1:0] row,
   input  logic [COL_W-1:0] col,
   input  dir_type          dir,
   input  logic [SZ_W-1:0]  rows_used,
   input  logic [SZ_W-1:0]  cols_used,
   output logic [ROW_W-1:0] nbr_row,
   output logic [COL_W-1:0] nbr_col,
   output logic             nbr_inside
);

   logic [SZ_W-1:0] row_ext;
   logic [SZ_W-1:0] col_ext;

   assign row_ext = SZ_W'(row);
   assign col_ext = SZ_W'(col);

   always_comb begin
      nbr_row    = row;
      nbr_col    = col;
      nbr_inside = 1'b0;
      unique case (dir)
         DIR_RIGHT: begin
            nbr_col    = col + COL_W'(1);
            nbr_inside = (col_ext + SZ_W'(1)) < cols_used;
         end
         DIR_DOWN: begin
            nbr_row    = row + ROW_W'(1);
            nbr_inside = (row_ext + SZ_W'(1)) < rows_used;
         end
         DIR_LEFT: begin
            nbr_col    = col - COL_W'(1);
            nbr_inside = (col != '0);
         end
         DIR_UP: begin
            nbr_row    = row - ROW_W'(1);
            nbr_inside = (row != '0);
         end
         default: begin
            nbr_inside = 1'b0;
         end
      endcase
   end

endmodule

FILE: hw/rtl/maze_path_dfs.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                  Payload
// req      in         req_tvalid / req_tready    tuser: op; tdata: cell_row, cell_col
// rsp      out        rsp_tvalid / rsp_tready    tuser: found; tdata: step_row, step_col;
//                                                tlast: last
// csr      in         csr_wr_en                  csr_index, csr_wdata
//
// A block request is written as it is taken; a clear request sweeps both grid stores. In a
// search, each neighbor probe (S_STEP then S_PROBE) and each backtrack (S_STEP then S_POP)
// waits on a registered read of the grid or stack memories, a neighbor off the grid is
// skipped in S_STEP alone, and each path cell is read (S_EMIT_RD) and then sent (S_EMIT).
// After reset a clearing pass over all 2**CELL_W cells (64 at the default size) runs before
// the first request is taken. A stalled response holds the search at the emitting cell.

module maze_path_dfs
   import mpd_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // cell_row, cell_col, zero fill
   input  logic [1:0]            req_tuser,  // op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,  // step_row, step_col, zero fill
   output logic [0:0]            rsp_tuser,  // found
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int CELL_W = ROW_W + COL_W;
   localparam int DEP_W  = CELL_W + 1;
   localparam int STK_W  = CELL_W + DIR_W;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_START_CHK,
      S_STEP,
      S_PROBE,
      S_POP,
      S_EMIT_RD,
      S_EMIT,
      S_MISS
   } state_type;

   logic [3:0]       num_rows_ff;
   logic [3:0]       num_cols_ff;
   logic [FLD_W-1:0] start_row_ff;
   logic [FLD_W-1:0] start_col_ff;
   logic [FLD_W-1:0] goal_row_ff;
   logic [FLD_W-1:0] goal_col_ff;

   state_type          state_ff, state_in;
   logic [ROW_W-1:0]   top_row_ff, top_row_in;
   logic [COL_W-1:0]   top_col_ff, top_col_in;
   logic [DIR_W-1:0]   top_dir_ff, top_dir_in;
   logic [ROW_W-1:0]   nxt_row_ff, nxt_row_in;
   logic [COL_W-1:0]   nxt_col_ff, nxt_col_in;
   logic [DEP_W-1:0]   depth_ff, depth_in;
   logic [DEP_W-1:0]   idx_ff, idx_in;
   logic [OUT_CNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic [CELL_W-1:0]  clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FLD_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [FLD_W-1:0]   rsp_col_ff, rsp_col_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [SZ_W-1:0]    rows_used;
   logic [SZ_W-1:0]    cols_used;
   logic [ROW_W-1:0]   nbr_row;
   logic [COL_W-1:0]   nbr_col;
   logic               nbr_inside;

   logic               blk_we, blk_wd, blk_re, blk_rd;
   logic [CELL_W-1:0]  blk_wa, blk_ra;
   logic               onp_we, onp_wd, onp_re, onp_rd;
   logic [CELL_W-1:0]  onp_wa, onp_ra;
   logic               stk_we, stk_re;
   logic [CELL_W-1:0]  stk_wa, stk_ra;
   logic [STK_W-1:0]   stk_wd, stk_rd;

   logic               req_take;
   logic               out_free;
   op_type             req_op;
   logic [FLD_W-1:0]   req_row;
   logic [FLD_W-1:0]   req_col;
   logic [DEP_W-1:0]   depth_m1;
   logic [DEP_W-1:0]   depth_m2;
   logic               start_inside;
   logic               at_goal;
   logic [ROW_W-1:0]   stk_row;
   logic [COL_W-1:0]   stk_col;
   logic               last_cell;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff  <= 4'd8;
         num_cols_ff  <= 4'd8;
         start_row_ff <= 3'd0;
         start_col_ff <= 3'd0;
         goal_row_ff  <= 3'd7;
         goal_col_ff  <= 3'd7;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NUM_ROWS:  num_rows_ff  <= csr_wdata;
            CSR_NUM_COLS:  num_cols_ff  <= csr_wdata;
            CSR_START_ROW: start_row_ff <= csr_wdata[FLD_W-1:0];
            CSR_START_COL: start_col_ff <= csr_wdata[FLD_W-1:0];
            CSR_GOAL_ROW:  goal_row_ff  <= csr_wdata[FLD_W-1:0];
            CSR_GOAL_COL:  goal_col_ff  <= csr_wdata[FLD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rows_used = (SZ_W'(num_rows_ff) > SZ_W'(MAX_ROWS)) ? SZ_W'(MAX_ROWS)
                                                              : SZ_W'(num_rows_ff);
   assign cols_used = (SZ_W'(num_cols_ff) > SZ_W'(MAX_COLS)) ? SZ_W'(MAX_COLS)
                                                              : SZ_W'(num_cols_ff);

   mpd_nbr #(
      .ROW_W(ROW_W),
      .COL_W(COL_W)
   ) u_nbr (
      .row       (top_row_ff),
      .col       (top_col_ff),
      .dir       (dir_type'(top_dir_ff[1:0])),
      .rows_used (rows_used),
      .cols_used (cols_used),
      .nbr_row   (nbr_row),
      .nbr_col   (nbr_col),
      .nbr_inside(nbr_inside)
   );

   mpd_ram #(.WIDTH(1), .ADDR_W(CELL_W)) u_blocked (
      .clock  (clock),
      .wr_en  (blk_we),
      .wr_addr(blk_wa),
      .wr_data(blk_wd),
      .rd_en  (blk_re),
      .rd_addr(blk_ra),
      .rd_data(blk_rd)
   );

   mpd_ram #(.WIDTH(1), .ADDR_W(CELL_W)) u_on_path (
      .clock  (clock),
      .wr_en  (onp_we),
      .wr_addr(onp_wa),
      .wr_data(onp_wd),
      .rd_en  (onp_re),
      .rd_addr(onp_ra),
      .rd_data(onp_rd)
   );

   mpd_ram #(.WIDTH(STK_W), .ADDR_W(CELL_W)) u_stack (
      .clock  (clock),
      .wr_en  (stk_we),
      .wr_addr(stk_wa),
      .wr_data(stk_wd),
      .rd_en  (stk_re),
      .rd_addr(stk_ra),
      .rd_data(stk_rd)
   );

   assign req_tready   = (state_ff == S_IDLE);
   assign req_take     = req_tvalid && req_tready;
   assign req_op       = op_type'(req_tuser);
   assign req_row      = req_tdata[FLD_W-1:0];
   assign req_col      = req_tdata[2*FLD_W-1:FLD_W];
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign depth_m1     = depth_ff - DEP_W'(1);
   assign depth_m2     = depth_ff - DEP_W'(2);
   assign start_inside = (SZ_W'(start_row_ff) < rows_used) &&
                         (SZ_W'(start_col_ff) < cols_used);
   assign at_goal      = (SZ_W'(top_row_ff) == SZ_W'(goal_row_ff)) &&
                         (SZ_W'(top_col_ff) == SZ_W'(goal_col_ff));
   assign stk_row      = stk_rd[CELL_W-1:COL_W];
   assign stk_col      = stk_rd[COL_W-1:0];
   assign last_cell    = (idx_ff == depth_m1);

   always_comb begin
      state_in     = state_ff;
      top_row_in   = top_row_ff;
      top_col_in   = top_col_ff;
      top_dir_in   = top_dir_ff;
      nxt_row_in   = nxt_row_ff;
      nxt_col_in   = nxt_col_ff;
      depth_in     = depth_ff;
      idx_in       = idx_ff;
      out_cnt_in   = out_cnt_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;

      blk_we = 1'b0;
      blk_wa = clr_ff;
      blk_wd = 1'b0;
      blk_re = 1'b0;
      blk_ra = {nbr_row, nbr_col};
      onp_we = 1'b0;
      onp_wa = clr_ff;
      onp_wd = 1'b0;
      onp_re = 1'b0;
      onp_ra = {nbr_row, nbr_col};
      stk_we = 1'b0;
      stk_wa = depth_m1[CELL_W-1:0];
      stk_wd = {top_dir_ff, top_row_ff, top_col_ff};
      stk_re = 1'b0;
      stk_ra = depth_m2[CELL_W-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            blk_we = 1'b1;
            onp_we = 1'b1;
            clr_in = clr_ff + CELL_W'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               unique case (req_op)
                  OP_BLOCK: begin
                     if ((SZ_W'(req_row) < SZ_W'(MAX_ROWS)) &&
                         (SZ_W'(req_col) < SZ_W'(MAX_COLS))) begin
                        blk_we = 1'b1;
                        blk_wa = {ROW_W'(req_row), COL_W'(req_col)};
                        blk_wd = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     clr_in   = '0;
                     state_in = S_CLEAR;
                  end
                  OP_SEARCH: begin
                     depth_in = '0;
                     state_in = S_START;
                  end
                  OP_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_START: begin
            blk_re     = 1'b1;
            blk_ra     = {ROW_W'(start_row_ff), COL_W'(start_col_ff)};
            top_row_in = ROW_W'(start_row_ff);
            top_col_in = COL_W'(start_col_ff);
            top_dir_in = '0;
            state_in   = S_START_CHK;
         end
         S_START_CHK: begin
            if (start_inside && !blk_rd) begin
               onp_we   = 1'b1;
               onp_wa   = {top_row_ff, top_col_ff};
               onp_wd   = 1'b1;
               depth_in = DEP_W'(1);
               state_in = S_STEP;
            end else begin
               state_in = S_MISS;
            end
         end
         S_STEP: begin
            if (at_goal) begin
               stk_we     = 1'b1;
               idx_in     = '0;
               out_cnt_in = '0;
               state_in   = S_EMIT_RD;
            end else if (top_dir_ff >= DIR_END) begin
               onp_we   = 1'b1;
               onp_wa   = {top_row_ff, top_col_ff};
               onp_wd   = 1'b0;
               depth_in = depth_m1;
               if (depth_m1 == '0) begin
                  state_in = S_MISS;
               end else begin
                  stk_re   = 1'b1;
                  state_in = S_POP;
               end
            end else begin
               top_dir_in = top_dir_ff + DIR_W'(1);
               if (nbr_inside) begin
                  blk_re     = 1'b1;
                  onp_re     = 1'b1;
                  nxt_row_in = nbr_row;
                  nxt_col_in = nbr_col;
                  state_in   = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (!blk_rd && !onp_rd) begin
               stk_we     = 1'b1;
               onp_we     = 1'b1;
               onp_wa     = {nxt_row_ff, nxt_col_ff};
               onp_wd     = 1'b1;
               top_row_in = nxt_row_ff;
               top_col_in = nxt_col_ff;
               top_dir_in = '0;
               depth_in   = depth_ff + DEP_W'(1);
            end
            state_in = S_STEP;
         end
         S_POP: begin
            top_row_in = stk_row;
            top_col_in = stk_col;
            top_dir_in = stk_rd[STK_W-1:CELL_W];
            state_in   = S_STEP;
         end
         S_EMIT_RD: begin
            stk_re   = 1'b1;
            stk_ra   = idx_ff[CELL_W-1:0];
            state_in = S_EMIT;
         end
         S_EMIT: begin
            onp_wa = {stk_row, stk_col};
            onp_wd = 1'b0;
            if (out_cnt_ff < OUT_CNT_W'(MAX_RESULTS)) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_row_in   = FLD_W'(stk_row);
                  rsp_col_in   = FLD_W'(stk_col);
                  rsp_found_in = 1'b1;
                  rsp_last_in  = last_cell ||
                                 (out_cnt_ff == OUT_CNT_W'(MAX_RESULTS - 1));
                  out_cnt_in   = out_cnt_ff + OUT_CNT_W'(1);
                  onp_we       = 1'b1;
               end
            end else begin
               onp_we = 1'b1;
            end
            if (onp_we) begin
               if (last_cell) begin
                  depth_in = '0;
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + DEP_W'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         S_MISS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = '0;
               rsp_col_in   = '0;
               rsp_found_in = 1'b0;
               rsp_last_in  = 1'b1;
               depth_in     = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         depth_ff     <= '0;
         idx_ff       <= '0;
         out_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         top_row_ff   <= '0;
         top_col_ff   <= '0;
         top_dir_ff   <= '0;
         nxt_row_ff   <= '0;
         nxt_col_ff   <= '0;
         rsp_row_ff   <= '0;
         rsp_col_ff   <= '0;
         rsp_found_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         depth_ff     <= depth_in;
         idx_ff       <= idx_in;
         out_cnt_ff   <= out_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         top_row_ff   <= top_row_in;
         top_col_ff   <= top_col_in;
         top_dir_ff   <= top_dir_in;
         nxt_row_ff   <= nxt_row_in;
         nxt_col_ff   <= nxt_col_in;
         rsp_row_ff   <= rsp_row_in;
         rsp_col_ff   <= rsp_col_in;
         rsp_found_ff <= rsp_found_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {{(8 - 2 * FLD_W){1'b0}}, rsp_col_ff, rsp_row_ff};
   assign rsp_tuser[0] = rsp_found_ff;
   assign rsp_tlast    = rsp_last_ff;

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> depth_ff == '0)
      else $error("Path stack is not empty while idle.");

   a_miss_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_last_ff && rsp_row_ff == '0 && rsp_col_ff == '0)
      else $error("Not-found response is malformed.");

   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STEP |-> top_dir_ff <= DIR_END)
      else $error("Direction counter ran past the last neighbor.");

   a_out_cap: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= OUT_CNT_W'(MAX_RESULTS))
      else $error("More path cells sent than allowed.");

endmodule

FILE: sim/maze_path_checker.sv
`timescale 1ns / 1ps

module maze_path_checker
   import mpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,  // cell_row, cell_col, zero fill
   input  logic [1:0]            req_tuser,  // op
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [7:0]            rsp_tdata,  // step_row, step_col, zero fill
   input  logic [0:0]            rsp_tuser,  // found
   input  logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    open_count
);

   localparam int GRID_CELLS = DEF_MAX_ROWS * DEF_MAX_COLS;

   typedef struct packed {
      logic [FLD_W-1:0] row;
      logic [FLD_W-1:0] col;
      logic             found;
      logic             last;
   } path_step_type;

   path_step_type         expected_steps[$];
   logic [GRID_CELLS-1:0] open_cells;
   logic [CSR_DATA_W-1:0] rows_cfg, cols_cfg;
   logic [FLD_W-1:0]      start_row, start_col, goal_row, goal_col;

   // Cells outside the rows and columns in use count as blocked.
   function automatic bit usable(int r, int c);
      int row_lim, col_lim;
      row_lim = (rows_cfg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows_cfg);
      col_lim = (cols_cfg > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cols_cfg);
      if (r < 0 || c < 0 || r >= row_lim || c >= col_lim) return 1'b0;
      return open_cells[r * DEF_MAX_COLS + c];
   endfunction

   function automatic void queue_step(input path_step_type nxt_step);
      expected_steps = {expected_steps, nxt_step};
   endfunction

   task automatic flag_step(input string what, input path_step_type want,
                            input path_step_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t %s: expected row %0d col %0d found %0d last %0d, got row %0d col %0d %s",
                  $realtime, what, want.row, want.col, want.found, want.last, got.row, got.col,
                  $sformatf("found %0d last %0d", got.found, got.last));
   endtask

   // Backtracking walk from the start cell, trying right, down, left, up in turn.
   task automatic trace_path();
      int                    trail_cell [GRID_CELLS];
      int                    trail_dir  [GRID_CELLS];
      logic [GRID_CELLS-1:0] marks;
      int                    depth, cur_cell, r, c, nr, nc, nx, goal;
      bit                    hit;
      path_step_type         s;
      marks = '0;
      hit = 1'b0;
      s = '0;
      if (!usable(int'(start_row), int'(start_col))) begin
         s.last = 1'b1;
         queue_step(s);
         return;
      end
      goal = int'(goal_row) * DEF_MAX_COLS + int'(goal_col);
      trail_cell[0] = int'(start_row) * DEF_MAX_COLS + int'(start_col);
      trail_dir[0] = 0;
      marks[trail_cell[0]] = 1'b1;
      depth = 1;
      while (depth > 0 && !hit) begin
         cur_cell = trail_cell[depth-1];
         if (cur_cell == goal) begin
            hit = 1'b1;
         end else if (trail_dir[depth-1] >= int'(DIR_END)) begin
            marks[cur_cell] = 1'b0;
            depth--;
         end else begin
            r = cur_cell / DEF_MAX_COLS;
            c = cur_cell % DEF_MAX_COLS;
            nr = r;
            nc = c;
            case (dir_type'(trail_dir[depth-1]))
               DIR_RIGHT: nc = c + 1;
               DIR_DOWN:  nr = r + 1;
               DIR_LEFT:  nc = c - 1;
               default:   nr = r - 1;
            endcase
            trail_dir[depth-1]++;
            if (usable(nr, nc)) begin
               nx = nr * DEF_MAX_COLS + nc;
               if (!marks[nx] && depth < GRID_CELLS) begin
                  marks[nx] = 1'b1;
                  trail_cell[depth] = nx;
                  trail_dir[depth] = 0;
                  depth++;
               end
            end
         end
      end
      if (!hit) begin
         s.last = 1'b1;
         queue_step(s);
         return;
      end
      if (depth > MAX_RESULTS) depth = MAX_RESULTS;
      for (int i = 0; i < depth; i++) begin
         s.row = FLD_W'(trail_cell[i] / DEF_MAX_COLS);
         s.col = FLD_W'(trail_cell[i] % DEF_MAX_COLS);
         s.found = 1'b1;
         s.last = (i == depth - 1);
         queue_step(s);
      end
   endtask

   always @(posedge clock) begin : watch
      path_step_type got, want;
      if (reset) begin
         expected_steps.delete();
         open_cells = '1;
         rows_cfg = CSR_DATA_W'(DEF_MAX_ROWS);
         cols_cfg = CSR_DATA_W'(DEF_MAX_COLS);
         start_row = '0;
         start_col = '0;
         goal_row = FLD_W'(DEF_MAX_ROWS - 1);
         goal_col = FLD_W'(DEF_MAX_COLS - 1);
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.row = rsp_tdata[FLD_W-1:0];
            got.col = rsp_tdata[2*FLD_W-1:FLD_W];
            got.found = rsp_tuser[0];
            got.last = rsp_tlast;
            if (expected_steps.size() == 0) begin
               flag_step("unexpected path step", '0, got);
            end else begin
               want = expected_steps.pop_front();
               if (got !== want) flag_step("path step mismatch", want, got);
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_NUM_ROWS:  rows_cfg = csr_wdata;
               CSR_NUM_COLS:  cols_cfg = csr_wdata;
               CSR_START_ROW: start_row = csr_wdata[FLD_W-1:0];
               CSR_START_COL: start_col = csr_wdata[FLD_W-1:0];
               CSR_GOAL_ROW:  goal_row = csr_wdata[FLD_W-1:0];
               CSR_GOAL_COL:  goal_col = csr_wdata[FLD_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            case (op_type'(req_tuser))
               OP_BLOCK:  open_cells[int'(req_tdata[FLD_W-1:0]) * DEF_MAX_COLS
                                     + int'(req_tdata[2*FLD_W-1:FLD_W])] = 1'b0;
               OP_CLEAR:  open_cells = '1;
               OP_SEARCH: trace_path();
               default: ;
            endcase
         end
      end
      open_count = expected_steps.size();
   end

endmodule

FILE: sim/tb_maze_path_dfs.sv
`timescale 1ns / 1ps

module tb_maze_path_dfs;
   import mpd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd6;
   localparam int ITEM_TARGET   = 450;
   localparam int IDLE_LIMIT    = 400000;
   localparam int SETTLE_CYCLES = 150;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_PHASE    = 3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;  // cell_row, cell_col, zero fill
   logic [1:0]            req_tuser  = OP_NONE;  // op
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;  // step_row, step_col, zero fill
   logic [0:0]            rsp_tuser;  // found
   logic                  rsp_tlast;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int fail_count, open_count;
   int sent        = 0;
   int idle_cycles = 0;
   int send_run    = 0;
   int recv_run    = 0;
   bit hold_request = 1'b0;

   always #10 clock = ~clock;

   maze_path_dfs dut (.*);

   maze_path_checker path_check (.*);

   function automatic int draw_gap(inout int run);
      if (run > 0) begin
         run--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         run = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic logic [2:0] pick_coord(int span);
      if ($urandom_range(0, 7) == 0) return 3'($urandom_range(0, 7));
      return 3'($urandom_range(0, span - 1));
   endfunction

   task automatic send(input op_type op, input logic [2:0] row, input logic [2:0] col);
      int gap;
      gap = draw_gap(send_run);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {2'b00, col, row};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      sent++;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] rows, cols, srow, scol, grow, gcol,
                            input bit with_spare);
      csr_write(CSR_NUM_ROWS, rows);
      csr_write(CSR_NUM_COLS, cols);
      csr_write(CSR_START_ROW, srow);
      csr_write(CSR_START_COL, scol);
      csr_write(CSR_GOAL_ROW, grow);
      csr_write(CSR_GOAL_COL, gcol);
      if (with_spare) csr_write(CSR_SPARE, 4'hF);
      csr_wr_en <= 1'b0;
   endtask

   // Holds the request side until every path step is back and the block has gone quiet.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : drain
      int gap;
      bit held;
      held = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (hold_request && !held) begin
            held = 1'b1;
            gap = HOLD_CYCLES;
         end else begin
            gap = draw_gap(recv_run);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int rows, cols, n, kind, phase;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send(OP_SEARCH, 3'd0, 3'd0);
      send(OP_NONE, 3'd7, 3'd7);
      send(OP_BLOCK, 3'd0, 3'd0);
      send(OP_SEARCH, 3'd7, 3'd7);
      send(OP_BLOCK, 3'd7, 3'd7);
      send(OP_CLEAR, 3'd5, 3'd2);
      send(OP_SEARCH, 3'd2, 3'd5);

      // On the open grid this goal forces a walk through every cell.
      quiesce();
      configure(8, 8, 0, 0, 1, 0, 1'b0);
      send(OP_SEARCH, 3'd0, 3'd0);

      quiesce();
      configure(15, 15, 3, 5, 3, 5, 1'b1);
      send(OP_SEARCH, 3'd0, 3'd0);

      quiesce();
      configure(15, 15, 3, 5, 0, 7, 1'b0);
      send(OP_BLOCK, 3'd3, 3'd6);
      send(OP_BLOCK, 3'd4, 3'd5);
      send(OP_BLOCK, 3'd3, 3'd4);
      send(OP_BLOCK, 3'd2, 3'd5);
      send(OP_SEARCH, 3'd0, 3'd0);
      send(OP_CLEAR, 3'd0, 3'd0);

      quiesce();
      configure(0, 8, 0, 0, 0, 0, 1'b0);
      send(OP_SEARCH, 3'd0, 3'd0);

      quiesce();
      configure(1, 0, 0, 0, 0, 0, 1'b0);
      send(OP_SEARCH, 3'd0, 3'd0);

      quiesce();
      configure(1, 8, 0, 7, 0, 0, 1'b0);
      send(OP_SEARCH, 3'd0, 3'd0);

      quiesce();
      configure(8, 1, 15, 0, 0, 0, 1'b0);
      send(OP_SEARCH, 3'd0, 3'd0);

      // Grids stay small or narrow so that a walk with no way out stays short.
      phase = 0;
      while (sent < ITEM_TARGET) begin
         quiesce();
         case ($urandom_range(0, 9))
            0: begin rows = 2; cols = 8; end
            1: begin rows = 8; cols = 2; end
            2: begin rows = 1; cols = 8; end
            3: begin rows = 8; cols = 1; end
            default: begin
               rows = $urandom_range(1, 4);
               cols = $urandom_range(1, 4);
            end
         endcase
         configure(4'(rows), 4'(cols),
                   {1'($urandom_range(0, 1)), pick_coord(rows)},
                   {1'($urandom_range(0, 1)), pick_coord(cols)},
                   {1'($urandom_range(0, 1)), pick_coord(rows)},
                   {1'($urandom_range(0, 1)), pick_coord(cols)}, 1'b0);
         if (phase == HOLD_PHASE) hold_request <= 1'b1;
         if ($urandom_range(0, 4) != 0) send(OP_CLEAR, 3'($urandom), 3'($urandom));
         n = $urandom_range(6, 18);
         repeat (n) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) send(OP_BLOCK, pick_coord(rows), pick_coord(cols));
            else if (kind < 85) send(OP_SEARCH, 3'($urandom), 3'($urandom));
            else if (kind < 92) send(OP_CLEAR, 3'($urandom), 3'($urandom));
            else send(OP_NONE, 3'($urandom), 3'($urandom));
         end
         phase++;
      end

      quiesce();
      if (fail_count == 0 && open_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/mpd_pkg.sv
hw/rtl/mpd_ram.sv
hw/rtl/mpd_nbr.sv
hw/rtl/maze_path_dfs.sv
sim/maze_path_checker.sv
sim/tb_maze_path_dfs.sv
